>>> rtl/core/per_second_byte_rate_limiter_core_defines.svh
// Assertion macros shared by the rate limiter RTL.
// Expects signals named clk and rst in the scope of use.
`ifndef PER_SECOND_BYTE_RATE_LIMITER_CORE_DEFINES_SVH
`define PER_SECOND_BYTE_RATE_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSBRL_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psbrl check failed");

// Next-cycle implication, disabled during reset.
`define PSBRL_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psbrl check failed");

`endif

>>> rtl/core/psbrl_pkg.sv
// Package for the per-second byte rate limiter: payload types, job type,
// register indexes and constants. No dependencies.
`default_nettype none

package psbrl_pkg;

  localparam int LIMIT_W         = 24;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int DIV_W           = 36;  // even: two quotient bits per step
  localparam int DIVISOR_W       = 10;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int LIMIT_FLOOR     = 100;
  localparam int PCT_DIV         = 100;
  localparam int MICROS_PER_SEC  = 1000000;
  localparam int MICROS_PER_MS   = 1000;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_REPORT  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAX        = 2'd0,
    CFG_RANGE_LOW  = 2'd1,
    CFG_RANGE_HIGH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JOB_REPORT = 2'd0,
    JOB_OPEN   = 2'd1,
    JOB_LIMIT  = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] pending_bytes;
    logic [31:0] now_seconds;
    logic [19:0] now_micros;
    logic [23:0] type_limit;
    logic [9:0]  connection_count;
    logic [30:0] random_word;
  } in_t;

  typedef struct packed {
    logic [15:0] grant_bytes;
    logic        delay_armed;
    logic [9:0]  delay_ms;
    logic [23:0] effective_limit;
  } out_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] pending_bytes;
    logic [31:0] now_seconds;
    logic [19:0] now_micros;
    logic [23:0] type_limit;
    logic [9:0]  connection_count;
    logic [30:0] random_word;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/core/per_second_byte_rate_limiter_core.sv
// Top level of the per-second byte rate limiter: front end, job queue and
// back end. Depends on psbrl_pkg, psbrl_front and psbrl_back.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------
//   in      | in  | in_valid/in_stall   | in_data  (psbrl_pkg::in_t)
//   out     | out | out_valid/out_stall | out_data (psbrl_pkg::out_t)
//   cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// Sequencing: reports and unlimited requests go from idle straight to the
//   output state in the back end; a limited request steps through the tax,
//   subtract, clamp and compare states, with a pass through the shared
//   two-bit-per-cycle divider for each of random offset, percent scaling and
//   delay_ms where needed, and the multiply when scaling is on.
// Reset: synchronous rst clears queue, sequencer, window state and config.
// Stalls: the front queue keeps taking beats while a result waits in the
//   output register; in_stall rises only when the queue is full.
`default_nettype none

module per_second_byte_rate_limiter_core #(
  parameter int QUEUE_DEPTH = psbrl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  psbrl_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output psbrl_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [psbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psbrl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import psbrl_pkg::*;

  // queue head toward the back end
  logic job_valid;
  logic job_pop;
  job_t job_data;

  // front: classify each request beat (report / unlimited / limited) and
  // queue it
  psbrl_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job_data  (job_data)
  );

  // back: window bookkeeping, tax, percent scaling, floor, budget cap, delay
  // and the registered result beat
  psbrl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job_data  (job_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/psbrl_div.sv
// Shared iterative unsigned divider, two quotient bits per cycle.
// Depends on psbrl_pkg for widths.
`default_nettype none

module psbrl_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [psbrl_pkg::DIV_W-1:0]     dividend,
  input  logic [psbrl_pkg::DIVISOR_W-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [psbrl_pkg::DIV_W-1:0]     quotient,
  output logic [psbrl_pkg::DIVISOR_W-1:0] remainder
);
  import psbrl_pkg::*;

  localparam int STEPS  = DIV_W / 2;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

  logic [DIV_W-1:0]     quo, quo_next;
  logic [DIVISOR_W-1:0] rem, rem_next, dvs;
  logic [STEP_W-1:0]    step;

  // two restoring steps; quotient bits shift in where dividend bits leave
  always_comb begin
    logic [DIVISOR_W:0] trial;
    trial    = '0;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < 2; i++) begin
      trial    = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      // one-cycle pulse after the last step
      done <= busy && !start && (step == STEP_LAST);
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= quo_next;
        rem <= rem_next;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

>>> rtl/core/psbrl_front.sv
// Front end: accepts input beats, classifies them into jobs and queues them
// for the back end. Depends on psbrl_pkg and the defines header.
`default_nettype none
`include "per_second_byte_rate_limiter_core_defines.svh"

module psbrl_front #(
  parameter int DEPTH = psbrl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  psbrl_pkg::in_t   in_data,
  output logic             job_valid,
  input  logic             job_pop,
  output psbrl_pkg::job_t  job_data
);
  import psbrl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             queue [DEPTH];
  job_t             job_in;
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;

  always_comb begin
    job_in.pending_bytes    = in_data.pending_bytes;
    job_in.now_seconds      = in_data.now_seconds;
    job_in.now_micros       = in_data.now_micros;
    job_in.type_limit       = in_data.type_limit;
    job_in.connection_count = in_data.connection_count;
    job_in.random_word      = in_data.random_word;
    priority if (in_data.operation == OP_REPORT) begin
      job_in.kind = JOB_REPORT;
    end else if (in_data.type_limit == '0) begin
      job_in.kind = JOB_OPEN;
    end else begin
      job_in.kind = JOB_LIMIT;
    end
  end

  assign in_stall  = (count == CNT_FULL);
  assign push      = in_valid && !in_stall;
  assign job_valid = (count != '0);
  assign job_data  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (job_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !job_pop) begin
        count <= count + 1'b1;
      end else if (job_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `PSBRL_CHECK(a_count_bound, 1'b1, count <= CNT_FULL)
  `PSBRL_CHECK(a_pop_nonempty, job_pop, count != '0)
  `PSBRL_CHECK_NEXT(a_push_grows, push && !job_pop, count == $past(count) + 1'b1)

endmodule

`default_nettype wire

>>> rtl/core/psbrl_back.sv
// Back end: window state, config registers, limit computation sequencer and
// the output register. Depends on psbrl_pkg, psbrl_div and the defines header.
`default_nettype none
`include "per_second_byte_rate_limiter_core_defines.svh"

module psbrl_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [psbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psbrl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             job_valid,
  output logic                             job_pop,
  input  psbrl_pkg::job_t                  job_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output psbrl_pkg::out_t                  out_data
);
  import psbrl_pkg::*;

  localparam int RL_W    = 31;  // signed working limit
  localparam int REM_W   = 34;  // signed remaining budget
  localparam int PCT_W   = DIVISOR_W + 1;
  localparam int TAXP_W  = 26;
  localparam int SPROD_W = LIMIT_W + PCT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_TAX, S_SUB, S_MOD, S_MUL, S_SCALE, S_CLAMP, S_CMP, S_DMS, S_EMIT
  } state_t;

  state_t state;

  logic [15:0]          tax_per_connection;
  logic [DIVISOR_W-1:0] range_low_percent;
  logic [DIVISOR_W-1:0] range_high_percent;

  logic [31:0] window_second;
  logic [31:0] window_bytes;
  logic [30:0] latched_random;

  job_t                    wk;
  out_t                    res;
  logic [TAXP_W-1:0]       tax_prod;
  logic [DIVISOR_W-1:0]    span;
  logic signed [RL_W-1:0]  rl;
  logic [PCT_W-1:0]        pct;

  logic                    div_start, div_busy, div_done;
  logic [DIV_W-1:0]        div_a, div_quo;
  logic [DIVISOR_W-1:0]    div_b, div_rem;

  logic [32:0]             wb_sum;
  logic [31:0]             wb_sat;
  logic [SPROD_W-1:0]      scale_prod;
  logic signed [REM_W-1:0] remaining;
  logic                    capped;
  logic                    emit;

  psbrl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign job_pop = (state == S_IDLE) && job_valid;

  always_comb begin
    wb_sum     = {1'b0, window_bytes} + 33'(job_data.pending_bytes);
    wb_sat     = wb_sum[32] ? '1 : wb_sum[31:0];
    scale_prod = SPROD_W'(rl[LIMIT_W-1:0]) * SPROD_W'(pct);
    remaining  = $signed(REM_W'(rl[RL_W-2:0])) - $signed(REM_W'(window_bytes));
    capped     = $signed(REM_W'(wk.pending_bytes)) > remaining;
    emit       = (state == S_EMIT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      div_start          <= 1'b0;
      tax_per_connection <= '0;
      range_low_percent  <= '0;
      range_high_percent <= '0;
      window_second      <= '0;
      window_bytes       <= '0;
      latched_random     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TAX:        tax_per_connection <= cfg_data;
          CFG_RANGE_LOW:  range_low_percent  <= cfg_data[DIVISOR_W-1:0];
          CFG_RANGE_HIGH: range_high_percent <= cfg_data[DIVISOR_W-1:0];
          default: ;
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            wk <= job_data;
            unique case (job_data.kind)
              JOB_REPORT: begin
                res          <= '0;
                window_bytes <= wb_sat;
                state        <= S_EMIT;
              end
              JOB_OPEN: begin
                res   <= '{grant_bytes: job_data.pending_bytes, default: '0};
                state <= S_EMIT;
              end
              JOB_LIMIT: begin
                res <= '0;
                if (job_data.now_seconds != window_second) begin
                  window_bytes  <= '0;
                  window_second <= job_data.now_seconds;
                  if (range_low_percent != '0) begin
                    latched_random <= job_data.random_word;
                  end
                end
                state <= S_TAX;
              end
              default: begin
                res   <= '0;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_TAX: begin
          tax_prod <= TAXP_W'(tax_per_connection) * TAXP_W'(wk.connection_count);
          span     <= (range_high_percent >= range_low_percent)
                      ? range_high_percent - range_low_percent
                      : range_low_percent - range_high_percent;
          state    <= S_SUB;
        end
        S_SUB: begin
          rl <= $signed(RL_W'(wk.type_limit)) - $signed(RL_W'(tax_prod));
          priority if (range_low_percent == '0) begin
            state <= S_CLAMP;
          end else if (span == '0) begin
            pct   <= PCT_W'(range_low_percent);
            state <= S_MUL;
          end else begin
            div_a     <= DIV_W'(latched_random);
            div_b     <= span;
            div_start <= 1'b1;
            state     <= S_MOD;
          end
        end
        S_MOD: begin
          div_start <= 1'b0;
          if (div_done) begin
            pct   <= PCT_W'(range_low_percent) + PCT_W'(div_rem);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (rl[RL_W-1] || rl == '0) begin
            rl    <= '0;
            state <= S_CLAMP;
          end else begin
            div_a     <= DIV_W'(scale_prod);
            div_b     <= DIVISOR_W'(PCT_DIV);
            div_start <= 1'b1;
            state     <= S_SCALE;
          end
        end
        S_SCALE: begin
          div_start <= 1'b0;
          if (div_done) begin
            rl    <= RL_W'(div_quo);
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (rl < $signed(RL_W'(LIMIT_FLOOR))) begin
            rl <= RL_W'(LIMIT_FLOOR);
          end
          state <= S_CMP;
        end
        S_CMP: begin
          res.effective_limit <= (rl[RL_W-2:LIMIT_W] != '0) ? '1 : rl[LIMIT_W-1:0];
          if (capped) begin
            res.delay_armed <= 1'b1;
            res.grant_bytes <= (remaining > 0) ? remaining[15:0] : '0;
            if (wk.now_micros < 20'(MICROS_PER_SEC)) begin
              div_a     <= DIV_W'(MICROS_PER_SEC) - DIV_W'(wk.now_micros);
              div_b     <= DIVISOR_W'(MICROS_PER_MS);
              div_start <= 1'b1;
              state     <= S_DMS;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            res.grant_bytes <= wk.pending_bytes;
            state           <= S_EMIT;
          end
        end
        S_DMS: begin
          div_start <= 1'b0;
          if (div_done) begin
            res.delay_ms <= div_quo[DIVISOR_W-1:0];
            state        <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSBRL_CHECK(a_div_idle_start, div_start, !div_busy)
  `PSBRL_CHECK(a_delay_only_armed, out_valid && !out_data.delay_armed,
               out_data.delay_ms == '0)
  `PSBRL_CHECK(a_limit_floor, out_valid && out_data.effective_limit != '0,
               out_data.effective_limit >= 24'(LIMIT_FLOOR))

endmodule

`default_nettype wire
